// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  // flags that go with one result item
  typedef struct packed {
    logic    is_empty;
    logic    is_full;
    status_t status;
  } res_flags_t;

endpackage

// ===== rtl/core/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/dq_ptr.sv =====
module dq_ptr #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  dq_pkg::op_t        op,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      front_addr,
  output logic [AW-1:0]      back_addr,
  output logic [CW-1:0]      count,
  output dq_pkg::res_flags_t flags
);

  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count_next;
  dq_pkg::status_t status, status_next;
  logic [AW-1:0]   head_dec, head_inc, tail;
  logic [AW:0]     tail_sum, back_sum;
  logic            full, empty;

  assign full  = (count == FULL_C);
  assign empty = (count == '0);

  assign head_dec = (head == '0) ? LAST : head - AW'(1);
  assign head_inc = (head == LAST) ? '0 : head + AW'(1);

  // slot after the back element; only used when not full
  assign tail_sum = (AW + 1)'(head) + (AW + 1)'(count);
  assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

  // back element; meaningless when empty, result is zeroed then
  assign back_sum   = (AW + 1)'(head) + (AW + 1)'(count) - (AW + 1)'(1);
  assign back_addr  = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
  assign front_addr = head;

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = tail;
    if (accept) begin
      status_next = dq_pkg::ST_OK;
      unique case (op) inside
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = dq_pkg::ST_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
            if (op == dq_pkg::OP_PUSH_FRONT) begin
              head_next = head_dec;
              wr_addr   = head_dec;
            end
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_next = dq_pkg::ST_UNDERFLOW;
          end else begin
            count_next = count - CW'(1);
            if (op == dq_pkg::OP_POP_FRONT) begin
              head_next = head_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      status <= dq_pkg::ST_OK;
    end else begin
      head   <= head_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  assign flags.is_empty = empty;
  assign flags.is_full  = full;
  assign flags.status   = status;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH entries, WIDTH bits each.
// Input channel (in_valid / in_stall): one item = operation + value.
//   operation: push front, push back, pop front, pop back.
// Output channel (out_valid / out_stall): exactly one result item per
//   input item, in order: front and back values after the operation
//   (zero when empty), is_empty, is_full, occupancy and status
//   (ok, overflow = push dropped, underflow = pop ignored).
// Timing: an item accepted at an edge writes the store (for a push) at
//   that edge; the front and back entries are then read in S_READ, and
//   the result is loaded into the output register in S_LOAD, so out_valid
//   is high in the cycle after that load. Each item goes through write,
//   then a registered read of the entry RAM, then load, before the next item is taken.
// in_stall is high while an item is in flight. A result waiting in the
//   output register does not hold off the next item; only a second
//   result ready while the first is still stalled waits in the load step.
// Reset clears head and count (queue empty) and drops any pending
//   result; the entry RAM is not cleared, its entries only reach a result
//   after a push has written them.
module double_ended_queue #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] front_value,
  output logic [31:0] back_value,
  output logic        is_empty,
  output logic        is_full,
  output logic [4:0]  occupancy,
  output logic [1:0]  status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dq_pkg::state_t     state, state_next;
  logic               accept, rd_en, load;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, front_addr, back_addr;
  logic [CW-1:0]      count;
  dq_pkg::res_flags_t flags;
  logic [WIDTH-1:0]   wdata, rdata_a, rdata_b;
  logic [WIDTH+31:0]  val_ext, front_ext, back_ext;
  logic [CW+4:0]      occ_ext;

  // value is cut or zero-extended to the stored width
  assign val_ext = {{WIDTH{1'b0}}, value};
  assign wdata   = val_ext[WIDTH-1:0];

  dq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (dq_pkg::op_t'(operation)),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .front_addr(front_addr),
    .back_addr (back_addr),
    .count     (count),
    .flags     (flags)
  );

  dq_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wdata),
    .re     (rd_en),
    .raddr_a(front_addr),
    .raddr_b(back_addr),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // sequencer: accept/write -> read -> load result
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      dq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = dq_pkg::S_READ;
        end
      end
      dq_pkg::S_READ: begin
        // pointers already updated, write already in the RAM
        rd_en      = 1'b1;
        state_next = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        // read data holds (no re) until the output register frees up
        load = !out_valid || !out_stall;
        if (load) begin
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign front_ext = {32'b0, rdata_a};
  assign back_ext  = {32'b0, rdata_b};
  assign occ_ext   = {5'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload; values forced to zero for an empty queue
  always_ff @(posedge clk) begin
    if (load) begin
      front_value <= flags.is_empty ? 32'b0 : front_ext[31:0];
      back_value  <= flags.is_empty ? 32'b0 : back_ext[31:0];
      is_empty    <= flags.is_empty;
      is_full     <= flags.is_full;
      occupancy   <= occ_ext[4:0];
      status      <= flags.status;
    end
  end

endmodule

// ===== rtl/core/dq_checker.sv =====
module dq_props (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] front_value,
  input logic [31:0] back_value,
  input logic        is_empty,
  input logic        is_full,
  input logic [4:0]  occupancy,
  input logic [1:0]  status
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_value) && $stable(status))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> occupancy == 5'd0 && front_value == 32'd0 && back_value == 32'd0)
    else $error("empty result with data");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("empty and full at once");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dq_pkg::ST_OVERFLOW |-> is_full)
    else $error("overflow while not full");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dq_pkg::ST_UNDERFLOW |-> is_empty)
    else $error("underflow while not empty");

endmodule

bind double_ended_queue dq_props u_dq_props (.*);
